/* rtl/keypoint_grid_window_search_defines.svh */
// ----------------------------------------------------------------------------
// Keypoint grid window search assertion macros
// Shared assertion helpers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef KEYPOINT_GRID_WINDOW_SEARCH_DEFINES_SVH
`define KEYPOINT_GRID_WINDOW_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property holds at every clock edge outside reset.
`define KGWS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keypoint grid assertion failed");
// Condition in one cycle implies the consequence in the next.
`define KGWS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("keypoint grid assertion failed");
`else
`define KGWS_ASSERT(label, prop)
`define KGWS_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* rtl/kgws_pkg.sv */
// ----------------------------------------------------------------------------
// Keypoint grid window search package
// Types, codes and fixed-point helpers shared by the grid search modules.
// ----------------------------------------------------------------------------
package kgws_pkg;

  // Default sizes of the grid and the keypoint store.
  localparam int unsigned GRID_COLUMNS_DEFAULT = 64;
  localparam int unsigned GRID_ROWS_DEFAULT    = 48;
  localparam int unsigned MAX_POINTS_DEFAULT   = 1024;
  localparam int unsigned MAX_HITS_DEFAULT     = 63;

  // Fixed-point layout: Q12.4 coordinates times Q0.16 inverses.
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned OPND_W    = 18;
  localparam int unsigned PROD_W    = 35;
  localparam int unsigned FRAC_BITS = 20;

  localparam logic [15:0] CELL_INV_RESET = 16'd6554;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Result codes.
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_HIT  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] CFG_CELL_W_INV = 2'd2;
  localparam logic [1:0] CFG_CELL_H_INV = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [2:0]         octave;
    logic [15:0]        radius;
    logic [2:0]         min_level;
    logic signed [3:0]  max_level;
  } req_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [9:0] keypoint_index;
    logic       in_grid;
    logic [5:0] hit_count;
    logic       overflow;
    logic       last;
  } rsp_t;

  // Classified request from the front end; cell bounds are signed grid units.
  // For an insert, lo_x and lo_y hold the rounded cell.
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [2:0]         octave;
    logic [15:0]        radius;
    logic [2:0]         min_level;
    logic signed [3:0]  max_level;
    logic signed [15:0] lo_x;
    logic signed [15:0] hi_x;
    logic signed [15:0] lo_y;
    logic signed [15:0] hi_y;
  } cmd_t;

  // One stored keypoint.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         octave;
  } pt_entry_t;

  typedef enum logic [1:0] {
    RND_NEAREST,
    RND_FLOOR,
    RND_CEIL
  } rnd_mode_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_DECODE,
    B_CLEAR,
    B_CLEAR_ACK,
    B_INS_LINK,
    B_INS_ACK,
    B_HEAD_RD,
    B_HEAD_CHK,
    B_PT_CHK,
    B_HIT,
    B_NEXT_CELL,
    B_DONE
  } back_state_e;

  localparam logic [PROD_W:0] FRAC_ONE_M1 = (PROD_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [PROD_W:0] FRAC_HALF   = (PROD_W + 1)'(64'd1 << (FRAC_BITS - 1));

  // Converts a product with 20 fraction bits to a grid coordinate.
  function automatic logic signed [15:0] to_cell(input logic signed [PROD_W-1:0] v,
                                                 input rnd_mode_e mode);
    logic signed [PROD_W:0] ext;
    logic signed [PROD_W:0] sum;
    logic [PROD_W:0]        mag;
    logic [15:0]            q;
    ext = (PROD_W + 1)'(v);
    mag = ext[PROD_W] ? (PROD_W + 1)'(-ext) : ext;
    mag = mag + FRAC_HALF;
    q   = 16'(mag >> FRAC_BITS);
    unique case (mode)
      RND_FLOOR: begin
        sum = ext;
        return 16'(sum >>> FRAC_BITS);
      end
      RND_CEIL: begin
        sum = ext + $signed(FRAC_ONE_M1);
        return 16'(sum >>> FRAC_BITS);
      end
      default: begin
        // Halves round away from zero.
        return ext[PROD_W] ? -$signed(q) : $signed(q);
      end
    endcase
  endfunction

endpackage

/* rtl/kgws_fifo.sv */
// ----------------------------------------------------------------------------
// Keypoint grid small queue
// Register-based first-in first-out queue for any packed payload type.
// ----------------------------------------------------------------------------
module kgws_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                   slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/kgws_front.sv */
// ----------------------------------------------------------------------------
// Keypoint grid front end
// Holds the configuration, accepts requests and maps coordinates to cells
// with one shared multiplier, then hands a classified command onward.
// ----------------------------------------------------------------------------
module kgws_front import kgws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  req_t        req_i,
  output logic        full_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        back_busy_i,
  output cmd_t        cmd_o,
  output logic        cmd_push_o,
  input  logic        cmd_full_i
);

  front_state_e             state_q, state_d;
  req_t                     req_q;
  logic [2:0]               step_q, step_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [15:0]       coord_q [4];
  logic signed [15:0]       origin_x_q, origin_y_q;
  logic [15:0]              w_inv_q, h_inv_q;

  logic                     accept, is_query, is_y, mul_en, conv_en;
  logic [2:0]               n_steps;
  logic [1:0]               k, conv_idx;
  logic signed [OPND_W-1:0] base, orig, rterm, opnd_a;
  logic signed [16:0]       opnd_b;
  rnd_mode_e                conv_mode;

  assign full_o  = (state_q != F_IDLE) || back_busy_i;
  assign accept  = push_i && !full_o;
  assign is_query = (req_q.req_type == REQ_QUERY);
  assign n_steps = is_query ? 3'd4 : 3'd2;
  assign k       = step_q[1:0];
  assign is_y    = is_query ? k[1] : k[0];
  assign conv_idx = 2'(step_q - 3'd1);
  assign conv_mode = !is_query ? RND_NEAREST : (conv_idx[0] ? RND_CEIL : RND_FLOOR);

  // Multiplier operands: offset from the origin, widened by the radius for queries.
  always_comb begin
    base   = is_y ? OPND_W'(req_q.point_y) : OPND_W'(req_q.point_x);
    orig   = is_y ? OPND_W'(origin_y_q) : OPND_W'(origin_x_q);
    rterm  = $signed({2'b00, req_q.radius});
    opnd_a = base - orig;
    if (is_query) begin
      opnd_a = k[0] ? opnd_a + rterm : opnd_a - rterm;
    end
    opnd_b = $signed({1'b0, is_y ? h_inv_q : w_inv_q});
  end

  // Next state and control.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    mul_en     = 1'b0;
    conv_en    = 1'b0;
    cmd_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        step_d = '0;
        if (accept) begin
          priority if (req_i.req_type == REQ_CLEAR) begin
            state_d = F_PUSH;
          end else if (req_i.req_type == REQ_INSERT || req_i.req_type == REQ_QUERY) begin
            state_d = F_CALC;
          end else begin
            state_d = F_IDLE;
          end
        end
      end
      F_CALC: begin
        mul_en  = (step_q < n_steps);
        conv_en = (step_q != 3'd0);
        step_d  = step_q + 1'b1;
        if (step_q == n_steps) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_push_o = !cmd_full_i;
        if (!cmd_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Request capture, product and converted cell bounds.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (mul_en) begin
      prod_q <= PROD_W'(opnd_a) * PROD_W'(opnd_b);
    end
    if (conv_en) begin
      coord_q[conv_idx] <= to_cell(prod_q, conv_mode);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      w_inv_q    <= CELL_INV_RESET;
      h_inv_q    <= CELL_INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:   origin_x_q <= $signed(cfg_data_i);
        CFG_ORIGIN_Y:   origin_y_q <= $signed(cfg_data_i);
        CFG_CELL_W_INV: w_inv_q    <= cfg_data_i;
        CFG_CELL_H_INV: h_inv_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command toward the back end.
  always_comb begin
    cmd_o.req_type  = req_q.req_type;
    cmd_o.point_x   = req_q.point_x;
    cmd_o.point_y   = req_q.point_y;
    cmd_o.octave    = req_q.octave;
    cmd_o.radius    = req_q.radius;
    cmd_o.min_level = req_q.min_level;
    cmd_o.max_level = req_q.max_level;
    cmd_o.lo_x      = coord_q[0];
    cmd_o.hi_x      = is_query ? coord_q[1] : coord_q[0];
    cmd_o.lo_y      = is_query ? coord_q[2] : coord_q[1];
    cmd_o.hi_y      = is_query ? coord_q[3] : coord_q[1];
  end

endmodule

/* rtl/kgws_back.sv */
// ----------------------------------------------------------------------------
// Keypoint grid back end
// Owns the keypoint store and the per-cell linked lists; links inserts,
// sweeps cell heads on clear and walks cell lists for window queries.
// ----------------------------------------------------------------------------
`include "keypoint_grid_window_search_defines.svh"

module kgws_back import kgws_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = GRID_COLUMNS_DEFAULT,
  parameter int unsigned GRID_ROWS    = GRID_ROWS_DEFAULT,
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEFAULT,
  parameter int unsigned MAX_HITS     = MAX_HITS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output rsp_t rsp_o,
  output logic rsp_push_o,
  input  logic rsp_full_i,
  output logic busy_o
);

  localparam int unsigned NCELLS = GRID_COLUMNS * GRID_ROWS;
  localparam int unsigned CA_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int unsigned COL_W  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int unsigned ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned PC_W   = $clog2(MAX_POINTS + 1);
  localparam logic signed [15:0] COL_LAST = 16'(GRID_COLUMNS - 1);
  localparam logic signed [15:0] ROW_LAST = 16'(GRID_ROWS - 1);

  // Memories: a link entry is a valid bit over a keypoint index.
  logic [IDX_W:0]   head_mem [NCELLS];
  logic [IDX_W-1:0] tail_mem [NCELLS];
  pt_entry_t        pt_mem   [MAX_POINTS];
  logic [IDX_W:0]   next_mem [MAX_POINTS];

  logic [IDX_W:0]   head_rd_q, next_rd_q;
  logic [IDX_W-1:0] tail_rd_q;
  pt_entry_t        pt_rd_q;

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CA_W-1:0]  sweep_q, sweep_d, cell_q, cell_d, col_base_q, col_base_d;
  logic [COL_W-1:0] col_q, col_d, col_end_q, col_end_d;
  logic [ROW_W-1:0] row_q, row_d, row_top_q, row_top_d, row_end_q, row_end_d;
  logic [PC_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d, ptr_q, ptr_d;
  logic             inside_q, inside_d, ovf_q, ovf_d;
  logic [5:0]       hits_q, hits_d;

  // Memory port controls.
  logic             head_we, head_re, tail_we, pt_we, next_we, pt_re;
  logic [CA_W-1:0]  head_wa;
  logic [IDX_W:0]   head_wd, next_wd;
  logic [IDX_W-1:0] next_wa, pt_ra;

  // Decode helpers.
  logic signed [15:0] lx, hx, ly, hy;
  logic               span_empty, in_range;
  logic [CA_W-1:0]    start_cell;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               level_ok, match;

  assign busy_o = (state_q == B_INIT);

  // Clamp the query span to the grid; also yields the insert cell.
  always_comb begin
    lx = (cmd_q.lo_x < 16'sd0) ? 16'sd0 : cmd_q.lo_x;
    hx = (cmd_q.hi_x > COL_LAST) ? COL_LAST : cmd_q.hi_x;
    ly = (cmd_q.lo_y < 16'sd0) ? 16'sd0 : cmd_q.lo_y;
    hy = (cmd_q.hi_y > ROW_LAST) ? ROW_LAST : cmd_q.hi_y;
    span_empty = (lx > hx) || (ly > hy);
    in_range = (cmd_q.lo_x >= 16'sd0) && (cmd_q.lo_x <= COL_LAST) &&
               (cmd_q.lo_y >= 16'sd0) && (cmd_q.lo_y <= ROW_LAST);
    start_cell = CA_W'(CA_W'(lx[COL_W-1:0]) * CA_W'(GRID_ROWS)) + CA_W'(ly[ROW_W-1:0]);
  end

  // Window and level test on the fetched keypoint.
  always_comb begin
    dx  = 17'(pt_rd_q.x) - 17'(cmd_q.point_x);
    dy  = 17'(pt_rd_q.y) - 17'(cmd_q.point_y);
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    level_ok = (pt_rd_q.octave >= cmd_q.min_level) &&
               (cmd_q.max_level[3] || (pt_rd_q.octave <= cmd_q.max_level[2:0]));
    match = level_ok && (adx < {1'b0, cmd_q.radius}) && (ady < {1'b0, cmd_q.radius});
  end

  // Sequencer: next state, register updates and memory controls.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    sweep_d    = sweep_q;
    cell_d     = cell_q;
    col_base_d = col_base_q;
    col_d      = col_q;
    col_end_d  = col_end_q;
    row_d      = row_q;
    row_top_d  = row_top_q;
    row_end_d  = row_end_q;
    count_d    = count_q;
    idx_d      = idx_q;
    ptr_d      = ptr_q;
    inside_d   = inside_q;
    ovf_d      = ovf_q;
    hits_d     = hits_q;
    cmd_pop_o  = 1'b0;
    rsp_push_o = 1'b0;
    rsp_o      = '0;
    head_we    = 1'b0;
    head_re    = 1'b0;
    head_wa    = cell_q;
    head_wd    = '0;
    tail_we    = 1'b0;
    pt_we      = 1'b0;
    next_we    = 1'b0;
    next_wa    = idx_q;
    next_wd    = '0;
    pt_re      = 1'b0;
    pt_ra      = head_rd_q[IDX_W-1:0];

    unique case (state_q)
      B_INIT, B_CLEAR: begin
        head_we = 1'b1;
        head_wa = sweep_q;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == CA_W'(NCELLS - 1)) begin
          state_d = (state_q == B_INIT) ? B_IDLE : B_CLEAR_ACK;
        end
      end
      B_IDLE: begin
        cmd_pop_o = !cmd_empty_i;
        if (!cmd_empty_i) begin
          cmd_d   = cmd_i;
          hits_d  = '0;
          ovf_d   = 1'b0;
          state_d = B_DECODE;
        end
      end
      B_DECODE: begin
        cell_d     = start_cell;
        col_base_d = start_cell - CA_W'(ly[ROW_W-1:0]);
        col_d      = lx[COL_W-1:0];
        col_end_d  = hx[COL_W-1:0];
        row_d      = ly[ROW_W-1:0];
        row_top_d  = ly[ROW_W-1:0];
        row_end_d  = hy[ROW_W-1:0];
        priority if (cmd_q.req_type == REQ_CLEAR) begin
          sweep_d = '0;
          count_d = '0;
          idx_d   = '0;
          state_d = B_CLEAR;
        end else if (cmd_q.req_type == REQ_INSERT) begin
          if (count_q >= PC_W'(MAX_POINTS)) begin
            // Store full: nothing is kept.
            idx_d    = '0;
            inside_d = 1'b0;
            ovf_d    = 1'b1;
            state_d  = B_INS_ACK;
          end else begin
            idx_d    = count_q[IDX_W-1:0];
            inside_d = in_range;
            pt_we    = 1'b1;
            next_we  = 1'b1;
            next_wa  = count_q[IDX_W-1:0];
            next_wd  = '0;
            count_d  = count_q + 1'b1;
            head_re  = in_range;
            state_d  = in_range ? B_INS_LINK : B_INS_ACK;
          end
        end else begin
          state_d = span_empty ? B_DONE : B_HEAD_RD;
        end
      end
      B_INS_LINK: begin
        // Append to the cell list: after the tail, or as the new head.
        if (head_rd_q[IDX_W]) begin
          next_we = 1'b1;
          next_wa = tail_rd_q;
          next_wd = {1'b1, idx_q};
        end else begin
          head_we = 1'b1;
          head_wd = {1'b1, idx_q};
        end
        tail_we = 1'b1;
        state_d = B_INS_ACK;
      end
      B_CLEAR_ACK, B_INS_ACK: begin
        rsp_o.result_kind    = KIND_ACK;
        rsp_o.keypoint_index = 10'(idx_q);
        rsp_o.in_grid        = (state_q == B_INS_ACK) && inside_q;
        rsp_o.overflow       = (state_q == B_INS_ACK) && ovf_q;
        rsp_o.last           = 1'b1;
        rsp_push_o           = !rsp_full_i;
        if (!rsp_full_i) begin
          state_d = B_IDLE;
        end
      end
      B_HEAD_RD: begin
        head_re = 1'b1;
        state_d = B_HEAD_CHK;
      end
      B_HEAD_CHK: begin
        if (head_rd_q[IDX_W]) begin
          pt_re   = 1'b1;
          pt_ra   = head_rd_q[IDX_W-1:0];
          ptr_d   = pt_ra;
          state_d = B_PT_CHK;
        end else begin
          state_d = B_NEXT_CELL;
        end
      end
      B_PT_CHK: begin
        pt_ra = next_rd_q[IDX_W-1:0];
        if (match) begin
          if (hits_q == 6'(MAX_HITS)) begin
            ovf_d   = 1'b1;
            state_d = B_DONE;
          end else begin
            state_d = B_HIT;
          end
        end else if (next_rd_q[IDX_W]) begin
          pt_re = 1'b1;
          ptr_d = pt_ra;
        end else begin
          state_d = B_NEXT_CELL;
        end
      end
      B_HIT: begin
        rsp_o.result_kind    = KIND_HIT;
        rsp_o.keypoint_index = 10'(ptr_q);
        rsp_push_o           = !rsp_full_i;
        pt_ra                = next_rd_q[IDX_W-1:0];
        if (!rsp_full_i) begin
          hits_d = hits_q + 1'b1;
          if (next_rd_q[IDX_W]) begin
            pt_re   = 1'b1;
            ptr_d   = pt_ra;
            state_d = B_PT_CHK;
          end else begin
            state_d = B_NEXT_CELL;
          end
        end
      end
      B_NEXT_CELL: begin
        // Column-major walk: down the rows, then on to the next column.
        if (row_q == row_end_q) begin
          if (col_q == col_end_q) begin
            state_d = B_DONE;
          end else begin
            col_d      = col_q + 1'b1;
            row_d      = row_top_q;
            col_base_d = col_base_q + CA_W'(GRID_ROWS);
            cell_d     = col_base_q + CA_W'(GRID_ROWS) + CA_W'(row_top_q);
            state_d    = B_HEAD_RD;
          end
        end else begin
          row_d   = row_q + 1'b1;
          cell_d  = cell_q + 1'b1;
          state_d = B_HEAD_RD;
        end
      end
      B_DONE: begin
        rsp_o.result_kind = KIND_DONE;
        rsp_o.hit_count   = hits_q;
        rsp_o.overflow    = ovf_q;
        rsp_o.last        = 1'b1;
        rsp_push_o        = !rsp_full_i;
        if (!rsp_full_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_INIT;
      sweep_q <= '0;
      count_q <= '0;
      hits_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      count_q <= count_d;
      hits_q  <= hits_d;
      ovf_q   <= ovf_d;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cell_q     <= cell_d;
    col_base_q <= col_base_d;
    col_q      <= col_d;
    col_end_q  <= col_end_d;
    row_q      <= row_d;
    row_top_q  <= row_top_d;
    row_end_q  <= row_end_d;
    idx_q      <= idx_d;
    ptr_q      <= ptr_d;
    inside_q   <= inside_d;
  end

  // Cell head and tail memories.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[cell_q] <= idx_q;
    end
    if (head_re) begin
      head_rd_q <= head_mem[cell_d];
      tail_rd_q <= tail_mem[cell_d];
    end
  end

  // Keypoint store and list links.
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[count_q[IDX_W-1:0]] <= '{x: cmd_q.point_x, y: cmd_q.point_y,
                                      octave: cmd_q.octave};
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (pt_re) begin
      pt_rd_q   <= pt_mem[pt_ra];
      next_rd_q <= next_mem[pt_ra];
    end
  end

  `KGWS_ASSERT(a_hit_limit, (rsp_push_o && state_q == B_HIT) |-> (hits_q < 6'(MAX_HITS)))
  `KGWS_ASSERT(a_no_pop_in_init, (state_q == B_INIT) |-> !cmd_pop_o)
  `KGWS_ASSERT(a_count_bound, count_q <= PC_W'(MAX_POINTS))
  `KGWS_ASSERT_NEXT(a_insert_counts, pt_we, count_q == PC_W'($past(count_q) + 1'b1))

endmodule

/* rtl/keypoint_grid_window_search.sv */
// Throughput: one request at a time in the grid unit; the front end maps the next
// requests meanwhile, so the list walks over single-port memories set the rate.
// Reset: cell heads are swept empty while full is held high.
// ----------------------------------------------------------------------------
// Keypoint grid window search
// Bins keypoints into a uniform grid and answers square-window queries.
// ----------------------------------------------------------------------------
module keypoint_grid_window_search import kgws_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = GRID_COLUMNS_DEFAULT,
  parameter int unsigned GRID_ROWS    = GRID_ROWS_DEFAULT,
  parameter int unsigned MAX_POINTS   = MAX_POINTS_DEFAULT,
  parameter int unsigned MAX_HITS     = MAX_HITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  req_t        req_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd_in, cmd_out;
  rsp_t rsp_in;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic rsp_push, rsp_full, back_busy;

  // Front end: configuration and cell mapping.
  kgws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .back_busy_i (back_busy),
    .cmd_o       (cmd_in),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full)
  );

  // Command queue between the two halves.
  kgws_fifo #(.T(cmd_t), .DEPTH(2)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back end: grid storage and list walks.
  kgws_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .MAX_POINTS   (MAX_POINTS),
    .MAX_HITS     (MAX_HITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_in),
    .rsp_push_o  (rsp_push),
    .rsp_full_i  (rsp_full),
    .busy_o      (back_busy)
  );

  // Result queue toward the consumer.
  kgws_fifo #(.T(rsp_t), .DEPTH(4)) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_in),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .data_o  (rsp_o),
    .empty_o (empty)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Keypoint grid window search testbench
// Drives clear, insert, window query and unused-code requests through the queue ports and
// checks every result against a behavioral grid model with random idling.
// ----------------------------------------------------------------------------
module tb;
  import kgws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          COLS        = int'(GRID_COLUMNS_DEFAULT);
  localparam int          ROWS        = int'(GRID_ROWS_DEFAULT);
  localparam int unsigned NPTS        = MAX_POINTS_DEFAULT;
  localparam int unsigned NHITS       = MAX_HITS_DEFAULT;
  localparam int unsigned SETTLE      = COLS * ROWS + 200;
  localparam longint      CYCLE_LIMIT = 20000000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  req_t        req_i;
  logic        full;
  logic        empty;
  logic        pop;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  keypoint_grid_window_search u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .req_i       (req_i),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Model copy of the registers and the grid contents.
  logic signed [15:0] org_x, org_y;
  logic [15:0]        inv_w, inv_h;
  logic signed [15:0] pt_x   [NPTS];
  logic signed [15:0] pt_y   [NPTS];
  logic [2:0]         pt_oct [NPTS];
  int unsigned        link_next [NPTS];
  bit                 link_ok   [NPTS];
  int unsigned        head_idx  [COLS*ROWS];
  bit                 head_ok   [COLS*ROWS];
  int unsigned        tail_idx  [COLS*ROWS];
  int unsigned        stored_pts;

  req_t   queued_reqs[$];
  rsp_t   expected_rsps[$];
  int     queued_total, accepted_total;
  int     send_idle, recv_idle;
  bit     hold_off;
  int     errors;
  longint cycles;

  // Clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint floor_q20(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint ceil_q20(longint v);
    return -floor_q20(-v);
  endfunction

  function automatic longint round_q20(longint v);
    longint half;
    half = longint'(1) << (FRAC_BITS - 1);
    if (v >= 0) begin
      return (v + half) >>> FRAC_BITS;
    end
    return -((-v + half) >>> FRAC_BITS);
  endfunction

  // Computes the results of one request and updates the grid model.
  task automatic search_grid_model(input req_t r);
    longint px, py, rad, ox, oy, wi, hi, lft, rgt, top, bot, cx, cy, dx, dy;
    int     hits, ml, o, c;
    int unsigned p;
    bit     ovf, more;
    rsp_t   e;
    px  = $signed(r.point_x);
    py  = $signed(r.point_y);
    rad = r.radius;
    ox  = org_x;
    oy  = org_y;
    wi  = inv_w;
    hi  = inv_h;
    ml  = $signed(r.max_level);
    e   = '0;
    case (r.req_type)
      REQ_CLEAR: begin
        foreach (head_ok[i]) head_ok[i] = 1'b0;
        stored_pts = 0;
        e.result_kind = KIND_ACK;
        e.last = 1'b1;
        expected_rsps = {expected_rsps, e};
      end
      REQ_INSERT: begin
        e.result_kind = KIND_ACK;
        e.last = 1'b1;
        if (stored_pts >= NPTS) begin
          e.overflow = 1'b1;
        end else begin
          p = stored_pts;
          pt_x[p] = r.point_x;
          pt_y[p] = r.point_y;
          pt_oct[p] = r.octave;
          link_ok[p] = 1'b0;
          stored_pts++;
          cx = round_q20((px - ox) * wi);
          cy = round_q20((py - oy) * hi);
          e.keypoint_index = p[9:0];
          if (cx >= 0 && cx < COLS && cy >= 0 && cy < ROWS) begin
            c = int'(cx) * ROWS + int'(cy);
            if (head_ok[c]) begin
              link_next[tail_idx[c]] = p;
              link_ok[tail_idx[c]] = 1'b1;
            end else begin
              head_idx[c] = p;
              head_ok[c] = 1'b1;
            end
            tail_idx[c] = p;
            e.in_grid = 1'b1;
          end
        end
        expected_rsps = {expected_rsps, e};
      end
      REQ_QUERY: begin
        lft  = floor_q20((px - rad - ox) * wi);
        rgt  = ceil_q20((px + rad - ox) * wi);
        top  = floor_q20((py - rad - oy) * hi);
        bot  = ceil_q20((py + rad - oy) * hi);
        hits = 0;
        ovf  = 1'b0;
        if (lft < 0) lft = 0;
        if (rgt > COLS - 1) rgt = COLS - 1;
        if (top < 0) top = 0;
        if (bot > ROWS - 1) bot = ROWS - 1;
        // Column-major cell walk, each list in insertion order.
        for (longint ix = lft; ix <= rgt && !ovf; ix++) begin
          for (longint iy = top; iy <= bot && !ovf; iy++) begin
            c = int'(ix) * ROWS + int'(iy);
            more = head_ok[c];
            p = head_idx[c];
            while (more) begin
              o  = pt_oct[p];
              dx = longint'(pt_x[p]) - px;
              dy = longint'(pt_y[p]) - py;
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              if (o >= r.min_level && !(ml >= 0 && o > ml) && dx < rad && dy < rad) begin
                if (hits >= NHITS) begin
                  ovf = 1'b1;
                  break;
                end
                e = '0;
                e.result_kind = KIND_HIT;
                e.keypoint_index = p[9:0];
                expected_rsps = {expected_rsps, e};
                hits++;
              end
              more = link_ok[p];
              p = link_next[p];
            end
          end
        end
        e = '0;
        e.result_kind = KIND_DONE;
        e.hit_count = hits[5:0];
        e.overflow = ovf;
        e.last = 1'b1;
        expected_rsps = {expected_rsps, e};
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Driver: offers queued requests and runs the model on each accepted one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        search_grid_model(req_i);
        accepted_total++;
      end
      if (!push || !full) begin
        if (queued_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          push  <= 1'b1;
          req_i <= queued_reqs.pop_front();
        end else begin
          push  <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes each result transaction and compares it with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_o);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("result_kind", e.result_kind, rsp_o.result_kind);
          check_field("keypoint_index", e.keypoint_index, rsp_o.keypoint_index);
          check_field("in_grid", e.in_grid, rsp_o.in_grid);
          check_field("hit_count", e.hit_count, rsp_o.hit_count);
          check_field("overflow", e.overflow, rsp_o.overflow);
          check_field("last", e.last, rsp_o.last);
        end
      end
      pop <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Long receiver stall while requests keep coming, so the block backs up.
  initial begin
    hold_off = 1'b0;
    wait (accepted_total >= 40);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic add_req(input int kind, input int x, input int y, input int oct,
                         input int rad, input int minl, input int maxl);
    req_t r;
    r.req_type  = kind[1:0];
    r.point_x   = x[15:0];
    r.point_y   = y[15:0];
    r.octave    = oct[2:0];
    r.radius    = rad[15:0];
    r.min_level = minl[2:0];
    r.max_level = maxl[3:0];
    queued_reqs = {queued_reqs, r};
    queued_total++;
  endtask

  // Span of the grid along one axis in Q12.4 units for the given inverse size.
  function automatic int grid_span(input logic [15:0] inv, input int n);
    longint s;
    s = (inv == 0) ? 65536 : (longint'(n) << FRAC_BITS) / inv;
    return (s > 65536) ? 65536 : int'(s);
  endfunction

  // Coordinate mostly on or near the grid, now and then anywhere.
  function automatic int near_coord(input int org, input logic [15:0] inv, input int n);
    int span, v;
    if ($urandom_range(99) < 10) begin
      return int'($urandom_range(65535)) - 32768;
    end
    span = grid_span(inv, n);
    v = org + int'($urandom_range(span + span / 8)) - span / 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic add_random(input int count);
    int roll, rad, span;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      span = grid_span(inv_w, COLS);
      rad  = ($urandom_range(99) < 85) ? $urandom_range(span / 6 + 16) : $urandom_range(65535);
      add_req((roll < 3) ? REQ_CLEAR : (roll < 5) ? 3 : (roll < 60) ? REQ_INSERT : REQ_QUERY,
              near_coord(org_x, inv_w, COLS), near_coord(org_y, inv_h, ROWS),
              $urandom_range(7), rad, ($urandom_range(99) < 60) ? 0 : $urandom_range(7),
              $urandom_range(15));
    end
  endtask

  // Waits until every queued request is taken and every result has arrived.
  task automatic drain;
    do @(posedge clk_i);
    while (accepted_total != queued_total || expected_rsps.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(input int ox, input int oy, input int wi, input int hi);
    int vals[4];
    vals = '{ox, oy, wi, hi};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= i[1:0];
      cfg_data_i  <= vals[i][15:0];
      case (i[1:0])
        CFG_ORIGIN_X:   org_x = vals[i][15:0];
        CFG_ORIGIN_Y:   org_y = vals[i][15:0];
        CFG_CELL_W_INV: inv_w = vals[i][15:0];
        default:        inv_h = vals[i][15:0];
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    push = 1'b0;
    pop = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ORIGIN_X;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    org_x = '0;
    org_y = '0;
    inv_w = CELL_INV_RESET;
    inv_h = CELL_INV_RESET;
    stored_pts = 0;
    foreach (head_ok[i]) head_ok[i] = 1'b0;
    queued_total = 0;
    accepted_total = 0;
    errors = 0;
    cycles = 0;
    send_idle = 18;
    recv_idle = 81;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rounding at half a cell, outside points, list linking, level filters.
    add_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    add_req(REQ_INSERT, 0, 0, 0, 0, 0, 0);
    add_req(REQ_INSERT, 80, 80, 7, 0, 0, 0);
    add_req(REQ_INSERT, 79, 0, 3, 0, 0, 0);
    add_req(REQ_INSERT, -80, -80, 5, 0, 0, 0);
    add_req(REQ_INSERT, 32767, -32768, 1, 0, 0, 0);
    add_req(REQ_INSERT, 10000, 7500, 2, 0, 0, 0);
    add_req(REQ_INSERT, 10160, 7600, 4, 0, 0, 0);
    add_req(REQ_INSERT, 0, 0, 6, 0, 0, 0);
    add_req(REQ_QUERY, 0, 0, 0, 0, 0, -1);
    add_req(REQ_QUERY, 0, 0, 0, 200, 0, -1);
    add_req(REQ_QUERY, 0, 0, 0, 200, 3, 5);
    add_req(REQ_QUERY, 0, 0, 0, 200, 7, 7);
    add_req(REQ_QUERY, 0, 0, 0, 65535, 0, -1);
    add_req(REQ_QUERY, -32768, -32768, 0, 65535, 0, -8);
    add_req(REQ_QUERY, 32767, 32767, 0, 1, 0, 7);
    add_req(3, -1, -1, 7, 65535, 7, -1);
    add_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    add_req(REQ_QUERY, 0, 0, 0, 65535, 0, -1);
    add_random(90);
    drain();

    // Extreme origins and inverse sizes.
    write_regs(-32768, 32767, 65535, 0);
    send_idle = 81;
    recv_idle = 18;
    add_random(40);
    drain();
    write_regs(32767, -32768, 0, 65535);
    add_random(40);
    drain();

    // Random traffic without idling.
    write_regs(1000, -500, 3000, 9000);
    send_idle = 0;
    recv_idle = 0;
    add_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) begin
      add_req(REQ_QUERY, near_coord(org_x, inv_w, COLS), near_coord(org_y, inv_h, ROWS),
              0, $urandom_range(65535), $urandom_range(7), $urandom_range(15));
    end
    add_random(66);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
